>>> design/mie_pkg.sv
package mie_pkg;

	localparam int DATA_WORDS = 4096;
	localparam int DM_AW = $clog2(DATA_WORDS);

	localparam logic [31:0] RST_START = 32'h0040_0000;
	localparam logic [31:0] RST_GP    = 32'h1000_8000;
	localparam logic [31:0] RST_SP    = 32'h7fff_fffc;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_GP    = 2'd1;
	localparam logic [1:0] CFG_SP    = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SYS  = 2'd1;
	localparam logic [1:0] ST_UNK  = 2'd2;
	localparam logic [1:0] ST_DIV0 = 2'd3;

	localparam logic [2:0] CL_SIMPLE = 3'd0;
	localparam logic [2:0] CL_MUL    = 3'd1;
	localparam logic [2:0] CL_DIV    = 3'd2;
	localparam logic [2:0] CL_LOAD   = 3'd3;
	localparam logic [2:0] CL_STORE  = 3'd4;

	localparam logic [5:0] FN_MULT  = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV   = 6'h1a;
	localparam logic [5:0] FN_DIVU  = 6'h1b;

	typedef struct packed {
		logic [31:0] instr;
		logic [2:0]  cls;
	} item_t;

	typedef struct packed {
		logic        start;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [31:0] nfa;
		logic        wen;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic        men;
		logic [31:0] maddr;
		logic [1:0]  st;
		logic [31:0] code;
	} res_t;

endpackage

>>> design/mie_front.sv
module mie_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           busy,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [31:0]    s_tdata,   // instruction
	output logic           q_valid,
	output mie_pkg::item_t q_item,
	input  logic           q_pop
);

	mie_pkg::item_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic [2:0] cls;
	logic [5:0] op, fn;

	assign op = s_tdata[31:26];
	assign fn = s_tdata[5:0];

	always_comb begin
		cls = mie_pkg::CL_SIMPLE;
		if (op == 6'h00) begin
			if (fn inside {mie_pkg::FN_MULT, mie_pkg::FN_MULTU}) cls = mie_pkg::CL_MUL;
			else if (fn inside {mie_pkg::FN_DIV, mie_pkg::FN_DIVU}) cls = mie_pkg::CL_DIV;
		end else if (op inside {6'h20, 6'h21, 6'h23, 6'h24, 6'h25}) begin
			cls = mie_pkg::CL_LOAD;
		end else if (op inside {6'h28, 6'h29, 6'h2b}) begin
			cls = mie_pkg::CL_STORE;
		end
	end

	assign s_tready = !busy && (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{instr: s_tdata, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

>>> design/mie_divider.sv
module mie_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  mie_pkg::div_req_t req,
	output mie_pkg::div_rsp_t rsp
);

	logic [31:0] rem_q, quo_q, d_q;
	logic        negq_q, negr_q, busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [32:0] tr;
	logic        na, nb;

	assign na = req.sgn && req.a[31];
	assign nb = req.sgn && req.b[31];
	assign tr = {rem_q, quo_q[31]};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= na ? (32'd0 - req.a) : req.a;
			d_q <= nb ? (32'd0 - req.b) : req.b;
			negq_q <= na ^ nb;
			negr_q <= na;
		end else if (busy_q) begin
			if (tr >= {1'b0, d_q}) begin
				rem_q <= 32'(tr - {1'b0, d_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= tr[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = negq_q ? (32'd0 - quo_q) : quo_q;
	assign rsp.rem = negr_q ? (32'd0 - rem_q) : rem_q;

endmodule

>>> design/mie_back.sv
module mie_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mie_pkg::item_t q_item,
	output logic           q_pop,
	output logic           busy,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_idx,
	input  logic [31:0]    cfg_val,
	output logic           out_valid,
	input  logic           out_ready,
	output mie_pkg::res_t  out_res
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_MEM  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [mie_pkg::DM_AW-1:0] clr_q;

	logic [31:0] rf [32];
	logic [31:0] rf_v_q;
	logic [31:0] rf_a_q, rf_b_q;
	logic        rf_av_q, rf_bv_q;
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic [4:0]  rb_idx;

	logic [31:0] dm [mie_pkg::DATA_WORDS];
	logic [31:0] dm_q;
	logic        dm_we;
	logic [mie_pkg::DM_AW-1:0] dm_wa, dm_ra;
	logic [31:0] dm_wd;

	logic [31:0] instr_q;
	logic [2:0]  cls_q;
	logic [31:0] pc_q, bt_q, hi_q, lo_q;
	logic        bp_q;
	logic [63:0] prod_s1;

	mie_pkg::res_t res_q;
	logic          ov_q;
	logic          out_load;

	mie_pkg::div_req_t dreq;
	mie_pkg::div_rsp_t drsp;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] imm, simm, a, b, ea, pc4, btgt;
	logic        wen, taken, skip, hi_a, lo_a, fin;
	logic [4:0]  widx;
	logic [31:0] wval, tgt, code, nxt, ld_val, merged, wval_f, maddr;
	logic [1:0]  st;
	logic [4:0]  sh;
	logic [31:0] hi_corr;

	function automatic logic [31:0] rst_val(input logic [4:0] i);
		case (i)
			5'd28: rst_val = mie_pkg::RST_GP;
			5'd29: rst_val = mie_pkg::RST_SP;
			5'd31: rst_val = mie_pkg::RST_START;
			default: rst_val = 32'd0;
		endcase
	endfunction

	assign op = instr_q[31:26];
	assign rs = instr_q[25:21];
	assign rt = instr_q[20:16];
	assign rd = instr_q[15:11];
	assign sa = instr_q[10:6];
	assign fn = instr_q[5:0];
	assign imm = {16'd0, instr_q[15:0]};
	assign simm = {{16{instr_q[15]}}, instr_q[15:0]};
	assign a = rf_av_q ? rf_a_q : rst_val(rs);
	assign b = rf_bv_q ? rf_b_q : rst_val(rt);
	assign ea = a + simm;
	assign pc4 = pc_q + 32'd4;
	assign btgt = pc4 + {simm[29:0], 2'b00};

	// Full decode of the held instruction; memory, multiply and divide results are
	// filled in by their own states.
	always_comb begin
		wen = 1'b0; widx = '0; wval = '0; taken = 1'b0; skip = 1'b0; tgt = '0;
		st = mie_pkg::ST_OK; code = '0; hi_a = 1'b0; lo_a = 1'b0;
		if (op == 6'h00) begin
			case (fn)
				6'h00: begin wen = 1'b1; widx = rd; wval = b << sa; end
				6'h02: begin wen = 1'b1; widx = rd; wval = b >> sa; end
				6'h03: begin wen = 1'b1; widx = rd; wval = $signed(b) >>> sa; end
				6'h04: begin wen = 1'b1; widx = rd; wval = b << a[4:0]; end
				6'h06: begin wen = 1'b1; widx = rd; wval = b >> a[4:0]; end
				6'h07: begin wen = 1'b1; widx = rd; wval = $signed(b) >>> a[4:0]; end
				6'h08: begin taken = 1'b1; tgt = a; end
				6'h09: begin
					wen = 1'b1; widx = rd; wval = pc_q + 32'd8; taken = 1'b1; tgt = a;
				end
				6'h0c: begin st = mie_pkg::ST_SYS; code = b; end
				6'h10: begin wen = 1'b1; widx = rd; wval = hi_q; end
				6'h11: hi_a = 1'b1;
				6'h12: begin wen = 1'b1; widx = rd; wval = lo_q; end
				6'h13: lo_a = 1'b1;
				mie_pkg::FN_MULT, mie_pkg::FN_MULTU: ;
				mie_pkg::FN_DIV, mie_pkg::FN_DIVU: if (b == 32'd0) st = mie_pkg::ST_DIV0;
				6'h20, 6'h21: begin wen = 1'b1; widx = rd; wval = a + b; end
				6'h22, 6'h23: begin wen = 1'b1; widx = rd; wval = a - b; end
				6'h24: begin wen = 1'b1; widx = rd; wval = a & b; end
				6'h25: begin wen = 1'b1; widx = rd; wval = a | b; end
				6'h26: begin wen = 1'b1; widx = rd; wval = a ^ b; end
				6'h27: begin wen = 1'b1; widx = rd; wval = ~(a | b); end
				6'h2a: begin
					wen = 1'b1; widx = rd; wval = {31'd0, $signed(a) < $signed(b)};
				end
				6'h2b: begin wen = 1'b1; widx = rd; wval = {31'd0, a < b}; end
				default: st = mie_pkg::ST_UNK;
			endcase
		end else if (op == 6'h01) begin
			if (rt[3] || rt[2]) begin
				st = mie_pkg::ST_UNK;
			end else begin
				if (rt[4]) begin wen = 1'b1; widx = 5'd31; wval = pc_q + 32'd8; end
				if (rt[0] ? !a[31] : a[31]) begin
					taken = 1'b1; tgt = btgt;
				end else if (rt[1]) begin
					skip = 1'b1;
				end
			end
		end else if (op == 6'h02 || op == 6'h03) begin
			taken = 1'b1;
			tgt = {pc4[31:28], instr_q[25:0], 2'b00};
			if (op == 6'h03) begin wen = 1'b1; widx = 5'd31; wval = pc_q + 32'd8; end
		end else if ((op & 6'h2c) == 6'h04) begin
			logic cond;
			case (op[1:0])
				2'd0: cond = (a == b);
				2'd1: cond = (a != b);
				2'd2: cond = (a == 32'd0) || a[31];
				default: cond = (a != 32'd0) && !a[31];
			endcase
			if (cond) begin
				taken = 1'b1; tgt = btgt;
			end else if (op[4]) begin
				skip = 1'b1;
			end
		end else begin
			case (op)
				6'h08, 6'h09: begin wen = 1'b1; widx = rt; wval = a + simm; end
				6'h0a: begin
					wen = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)};
				end
				6'h0b: begin wen = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
				6'h0c: begin wen = 1'b1; widx = rt; wval = a & imm; end
				6'h0d: begin wen = 1'b1; widx = rt; wval = a | imm; end
				6'h0e: begin wen = 1'b1; widx = rt; wval = a ^ imm; end
				6'h0f: begin wen = 1'b1; widx = rt; wval = {instr_q[15:0], 16'd0}; end
				6'h20, 6'h21, 6'h23, 6'h24, 6'h25: begin wen = 1'b1; widx = rt; end
				6'h28, 6'h29, 6'h2b: ;
				default: st = mie_pkg::ST_UNK;
			endcase
		end
	end

	// Load extraction and store merge on the word read in the previous cycle.
	always_comb begin
		logic [7:0]  by;
		logic [15:0] hw;
		by = 8'(dm_q >> {~ea[1:0], 3'b000});
		hw = ea[1] ? dm_q[15:0] : dm_q[31:16];
		case (op)
			6'h20: ld_val = {{24{by[7]}}, by};
			6'h24: ld_val = {24'd0, by};
			6'h21: ld_val = {{16{hw[15]}}, hw};
			6'h25: ld_val = {16'd0, hw};
			default: ld_val = dm_q;
		endcase
		case (op)
			6'h28: begin
				sh = {~ea[1:0], 3'b000};
				merged = (dm_q & ~(32'h0000_00ff << sh)) | ({24'd0, b[7:0]} << sh);
				maddr = ea;
			end
			6'h29: begin
				sh = ea[1] ? 5'd0 : 5'd16;
				merged = (dm_q & ~(32'h0000_ffff << sh)) | ({16'd0, b[15:0]} << sh);
				maddr = {ea[31:1], 1'b0};
			end
			default: begin
				sh = 5'd0;
				merged = b;
				maddr = {ea[31:2], 2'b00};
			end
		endcase
	end

	assign hi_corr = prod_s1[63:32] - ((fn == mie_pkg::FN_MULT && a[31]) ? b : 32'd0)
		- ((fn == mie_pkg::FN_MULT && b[31]) ? a : 32'd0);

	assign fin = (state_q == S_EXEC && (cls_q == mie_pkg::CL_SIMPLE
			|| (cls_q == mie_pkg::CL_DIV && b == 32'd0)))
		|| state_q == S_MEM || state_q == S_MUL || (state_q == S_DIV && drsp.done);

	assign wval_f = (state_q == S_MEM && cls_q == mie_pkg::CL_LOAD) ? ld_val : wval;

	always_comb begin
		if (bp_q) nxt = bt_q;
		else if (taken) nxt = pc4;
		else if (skip) nxt = pc_q + 32'd8;
		else nxt = pc4;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign busy = (state_q == S_CLR);
	assign rb_idx = (q_item.instr[31:26] == 6'h00 && q_item.instr[5:0] == 6'h0c)
		? 5'd2 : q_item.instr[20:16];

	always_comb begin
		rf_we = 1'b0; rf_wa = '0; rf_wd = cfg_val;
		if (cfg_we && cfg_idx != 2'd3) begin
			rf_we = 1'b1;
			case (cfg_idx)
				mie_pkg::CFG_START: rf_wa = 5'd31;
				mie_pkg::CFG_GP: rf_wa = 5'd28;
				default: rf_wa = 5'd29;
			endcase
		end else if (fin && wen && widx != 5'd0) begin
			rf_we = 1'b1; rf_wa = widx; rf_wd = wval_f;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		if (q_pop) begin
			rf_a_q <= rf[q_item.instr[25:21]];
			rf_b_q <= rf[rb_idx];
		end
	end

	assign dm_we = (state_q == S_CLR) || (state_q == S_MEM && cls_q == mie_pkg::CL_STORE);
	assign dm_wa = (state_q == S_CLR) ? clr_q : ea[mie_pkg::DM_AW+1:2];
	assign dm_wd = (state_q == S_CLR) ? 32'd0 : merged;
	assign dm_ra = ea[mie_pkg::DM_AW+1:2];

	always_ff @(posedge clk) begin
		if (dm_we) dm[dm_wa] <= dm_wd;
		dm_q <= dm[dm_ra];
	end

	assign dreq.start = (state_q == S_EXEC) && (cls_q == mie_pkg::CL_DIV) && (b != 32'd0);
	assign dreq.sgn = (fn == mie_pkg::FN_DIV);
	assign dreq.a = a;
	assign dreq.b = b;

	mie_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			instr_q <= q_item.instr;
			cls_q <= q_item.cls;
		end
		if (state_q == S_EXEC) prod_s1 <= a * b;
		if (fin) begin
			res_q.nfa <= nxt;
			res_q.wen <= wen && (widx != 5'd0);
			res_q.widx <= (wen && widx != 5'd0) ? widx : 5'd0;
			res_q.wval <= (wen && widx != 5'd0) ? wval_f : 32'd0;
			res_q.men <= (state_q == S_MEM && cls_q == mie_pkg::CL_STORE);
			res_q.maddr <= (state_q == S_MEM && cls_q == mie_pkg::CL_STORE) ? maddr : 32'd0;
			res_q.st <= st;
			res_q.code <= code;
		end
		if (out_load) out_res <= res_q;
	end

	assign out_load = (state_q == S_DONE) && (!ov_q || out_ready);
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			rf_v_q <= '0;
			rf_av_q <= 1'b0;
			rf_bv_q <= 1'b0;
			pc_q <= mie_pkg::RST_START;
			bp_q <= 1'b0;
			bt_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (rf_we) rf_v_q[rf_wa] <= 1'b1;
			if (q_pop) begin
				rf_av_q <= rf_v_q[q_item.instr[25:21]];
				rf_bv_q <= rf_v_q[rb_idx];
			end
			if (out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (fin) begin
				pc_q <= nxt;
				bp_q <= !bp_q && taken;
				if (!bp_q && taken) bt_q <= tgt;
				if (hi_a) hi_q <= a;
				if (lo_a) lo_q <= a;
				if (state_q == S_MUL) begin
					hi_q <= hi_corr;
					lo_q <= prod_s1[31:0];
				end
				if (state_q == S_DIV) begin
					hi_q <= drsp.rem;
					lo_q <= drsp.quo;
				end
			end
			if (cfg_we && cfg_idx == mie_pkg::CFG_START) begin
				pc_q <= cfg_val;
				bp_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (fin) state_q <= S_DONE;
					else if (cls_q == mie_pkg::CL_MUL) state_q <= S_MUL;
					else if (cls_q == mie_pkg::CL_DIV) state_q <= S_DIV;
					else state_q <= S_MEM;
				end
				S_MEM, S_MUL: state_q <= S_DONE;
				S_DIV: if (drsp.done) state_q <= S_DONE;
				S_DONE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == S_DONE) else $error("finished item did not reach the result state");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ov_q) else $error("result register not marked full after load");
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !q_pop) else $error("item taken during memory clear");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV) else $error("divider finished outside divide state");

endmodule

>>> design/mips32_instruction_executor_core.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    s_tdata[31:0] instruction
// m_       out        m_tvalid/m_tready    m_tdata result fields, m_tuser[1:0] status
// cfg_     in         cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
// Each item runs through the execute sequencer one at a time: ALU, branch and jump items
// take the register file read and the execute state, loads and stores add the data memory
// read-modify-write, multiplies the product register, and divides the radix-2 divider
// (skipped when the divisor is zero).
// After reset a clearing pass writes zero to all 4096 data memory words, one per cycle,
// and no item is taken during the pass; configuration writes are always taken.
// A two-entry queue lets the input side keep accepting while the sequencer works, and the
// result register lets the next item start while a result waits on m_tready.
module mips32_instruction_executor_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // [31:0] instruction
	output logic          m_tvalid,
	input  logic          m_tready,
	// [31:0] next_fetch_address, [32] reg_write_enable, [37:33] reg_write_index,
	// [69:38] reg_write_value, [70] mem_write_enable, [102:71] mem_write_address,
	// [134:103] syscall_code, [135] zero
	output logic [135:0]  m_tdata,
	output logic [1:0]    m_tuser,   // [1:0] status
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	logic           q_valid, q_pop, busy;
	mie_pkg::item_t q_item;
	mie_pkg::res_t  res;

	assign cfg_ready = 1'b1;

	mie_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.busy(busy),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	mie_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.busy(busy),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_idx(cfg_index),
		.cfg_val(cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(res)
	);

	assign m_tdata = {1'b0, res.code, res.maddr, res.men, res.wval, res.widx, res.wen, res.nfa};
	assign m_tuser = res.st;

endmodule
